@@ hw/rtl/etf_pkg.sv @@
// Shared types and constants for the escape-time fractal pixel engine.
// No dependencies; imported by the channel interfaces and the top level.
package etf_pkg;

  localparam int CW         = 32;             // coordinate and register width
  localparam int FRAC_BITS  = 28;             // Q4.28 fixed point
  localparam int SUM_W      = 40;             // headroom for sums before saturation
  localparam int MUL_W      = CW + 1;         // multiplier operand width
  localparam int PROD_W     = 64;             // kept product width
  localparam int POS_W      = 10;
  localparam int CNT_W      = 10;
  localparam int COLOR_W    = 24;
  localparam int SPAN_PIXELS = 1024;          // must be a power of two
  localparam int SPAN_SHIFT  = $clog2(SPAN_PIXELS);
  localparam int DIV_W      = CNT_W + 8;      // count * 255 fits here
  localparam int DIV_CNT_W  = $clog2(DIV_W);
  localparam int CFG_IDX_W  = 3;

  localparam logic signed [SUM_W-1:0] ESC_BOUND = SUM_W'(4) <<< FRAC_BITS;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ITER_LIMIT = 3'd0,
    REG_SET_SELECT = 3'd1,
    REG_JULIA_RE   = 3'd2,
    REG_JULIA_IM   = 3'd3,
    REG_RE_MIN     = 3'd4,
    REG_RE_MAX     = 3'd5,
    REG_IM_MIN     = 3'd6,
    REG_IM_MAX     = 3'd7
  } cfg_reg_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAP_RE,
    S_MAP_IM,
    S_INIT,
    S_SQ_R,
    S_SQ_I,
    S_CHECK,
    S_STEP,
    S_DIV,
    S_EMIT
  } etf_state_t;

  // Clamp a wide signed sum to the signed 32-bit range.
  function automatic logic signed [CW-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'({1'b0, {(CW-1){1'b1}}});
    lo = -hi - SUM_W'(1);
    if (v > hi) begin
      return {1'b0, {(CW-1){1'b1}}};
    end else if (v < lo) begin
      return {1'b1, {(CW-1){1'b0}}};
    end
    return v[CW-1:0];
  endfunction

endpackage

@@ hw/rtl/etf_pixel_if.sv @@
// Input channel carrying one pixel position per word.
// Depends on etf_pkg for field widths.
interface etf_pixel_if
  import etf_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] pixel_col;
  logic [POS_W-1:0] pixel_row;

  modport source (output valid, output pixel_col, output pixel_row, input ready);
  modport sink   (input valid, input pixel_col, input pixel_row, output ready);
endinterface

@@ hw/rtl/etf_result_if.sv @@
// Output channel carrying the evaluated pixel: position echo, count and color.
// Depends on etf_pkg for field widths.
interface etf_result_if
  import etf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [POS_W-1:0]   out_col;
  logic [POS_W-1:0]   out_row;
  logic [CNT_W-1:0]   escape_count;
  logic [COLOR_W-1:0] pixel_color;

  modport source (output valid, output out_col, output out_row, output escape_count,
                  output pixel_color, input ready);
  modport sink   (input valid, input out_col, input out_row, input escape_count,
                  input pixel_color, output ready);
endinterface

@@ hw/rtl/escape_time_fractal_pixel.sv @@
// Escape-time fractal pixel engine (Mandelbrot or Julia), Q4.28 fixed point.
// Depends on etf_pkg, etf_pixel_if and etf_result_if.
//
// Usage: a pixel word (pixel_col, pixel_row) enters on the pixel channel;
// one result word (out_col, out_row, escape_count, pixel_color) leaves on the
// result channel. Both use valid/ready; a word moves when both are high.
// Registers are written through cfg_we / cfg_index / cfg_wdata, one per cycle;
// the user must write them only while no pixel is in flight; nothing checks it.
//
// Datapath: one 33x33 signed multiplier, registered, serves every product.
// Mapping the position comes first, then setup, then the iterations (cross
// product, step, two squares with the escape test), and an escaped pixel is
// colored by a bit-serial divider. The result is then loaded into the output
// register; the engine returns to idle and can accept the next pixel.
// pixel.ready is high only while idle.
// The result sits in an output register; the next pixel is accepted while it
// waits, and a pixel that finishes before the receiver takes the previous
// word holds until the register frees up.
// Reset (rst, synchronous) returns the registers to their defaults
// (limit 100, Mandelbrot, window -2..2) and empties the pipeline.
module escape_time_fractal_pixel
  import etf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  etf_pixel_if.sink            pixel,
  etf_result_if.source         result,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CW-1:0]        cfg_wdata
);

  // Configuration registers
  logic [CNT_W-1:0]     iter_limit;
  logic                 set_select;
  logic signed [CW-1:0] julia_re;
  logic signed [CW-1:0] julia_im;
  logic signed [CW-1:0] re_min;
  logic signed [CW-1:0] re_max;
  logic signed [CW-1:0] im_min;
  logic signed [CW-1:0] im_max;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_limit <= CNT_W'(100);
      set_select <= 1'b1;
      julia_re   <= '0;
      julia_im   <= '0;
      re_min     <= -(CW'(1) <<< (FRAC_BITS + 1));
      re_max     <=  (CW'(1) <<< (FRAC_BITS + 1));
      im_min     <= -(CW'(1) <<< (FRAC_BITS + 1));
      im_max     <=  (CW'(1) <<< (FRAC_BITS + 1));
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ITER_LIMIT: iter_limit <= cfg_wdata[CNT_W-1:0];
        REG_SET_SELECT: set_select <= cfg_wdata[0];
        REG_JULIA_RE:   julia_re   <= cfg_wdata;
        REG_JULIA_IM:   julia_im   <= cfg_wdata;
        REG_RE_MIN:     re_min     <= cfg_wdata;
        REG_RE_MAX:     re_max     <= cfg_wdata;
        REG_IM_MIN:     im_min     <= cfg_wdata;
        REG_IM_MAX:     im_max     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer
  etf_state_t state, state_next;

  logic [POS_W-1:0]       col, row;
  logic signed [CW-1:0]   point_re;
  logic signed [CW-1:0]   zr, zi, cre, cim;
  logic signed [SUM_W-1:0] sqr, sqi;
  logic [CNT_W-1:0]       n;
  logic                   stepped;
  logic signed [PROD_W-1:0] prod;
  logic [CNT_W-1:0]       div_rem;
  logic [DIV_W-1:0]       div_num;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [CNT_W-1:0]       res_count;
  logic [COLOR_W-1:0]     res_color;
  logic                   out_valid;

  // Shared multiplier: operands picked by state, product registered
  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_full;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_MAP_RE: begin
        mul_a = signed'({{(MUL_W-POS_W){1'b0}}, col});
        mul_b = {re_max[CW-1], re_max} - {re_min[CW-1], re_min};
      end
      S_MAP_IM: begin
        mul_a = signed'({{(MUL_W-POS_W){1'b0}}, row});
        mul_b = {im_max[CW-1], im_max} - {im_min[CW-1], im_min};
      end
      S_SQ_R: begin
        mul_a = {zr[CW-1], zr};
        mul_b = {zr[CW-1], zr};
      end
      S_SQ_I: begin
        mul_a = {zi[CW-1], zi};
        mul_b = {zi[CW-1], zi};
      end
      S_CHECK: begin
        mul_a = {zr[CW-1], zr};
        mul_b = {zi[CW-1], zi};
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_full[PROD_W-1:0];
  end

  // Position map: min + trunc(pos*range / SPAN_PIXELS), saturated
  logic signed [PROD_W-1:0] map_adj, map_shr;
  logic signed [SUM_W-1:0]  map_t;
  logic signed [CW-1:0]     map_lo;
  logic signed [CW-1:0]     map_val;

  always_comb begin
    map_lo  = (state == S_MAP_IM) ? re_min : im_min;
    map_adj = prod + ((prod < 0) ? PROD_W'(SPAN_PIXELS - 1) : PROD_W'(0));
    map_shr = map_adj >>> SPAN_SHIFT;
    map_t   = map_shr[SUM_W-1:0];
    map_val = sat32(map_t + SUM_W'(map_lo));
  end

  // Iteration arithmetic
  logic signed [PROD_W-1:0] sq_shr, cr_shr;
  logic signed [SUM_W-1:0]  sq_now, cr_now;
  logic signed [CW-1:0]     zr_next, zi_next;
  logic                     escaped;
  logic [CNT_W-1:0]         n_cur;
  logic                     at_limit;

  always_comb begin
    sq_shr   = prod >>> FRAC_BITS;
    cr_shr   = prod >>> (FRAC_BITS - 1);
    sq_now   = sq_shr[SUM_W-1:0];
    cr_now   = cr_shr[SUM_W-1:0];
    zr_next  = sat32(sqr - sqi + SUM_W'(cre));
    zi_next  = sat32(cr_now + SUM_W'(cim));
    escaped  = stepped && ((sqr + sq_now) > ESC_BOUND);
    n_cur    = stepped ? n + CNT_W'(1) : n;
    at_limit = (n_cur == iter_limit);
  end

  // Restoring divider step for v = n*255 / limit
  logic [CNT_W:0]     div_trial;
  logic               div_ge;
  logic [CNT_W-1:0]   div_rem_next;
  logic [DIV_W-1:0]   div_num_next;
  logic [7:0]         v;
  logic [15:0]        v_sq;
  logic [COLOR_W-1:0] color_calc;

  always_comb begin
    div_trial    = {div_rem, div_num[DIV_W-1]};
    div_ge       = (div_trial >= {1'b0, iter_limit});
    div_rem_next = div_ge ? CNT_W'(div_trial - {1'b0, iter_limit}) : div_trial[CNT_W-1:0];
    div_num_next = {div_num[DIV_W-2:0], div_ge};
    v            = div_num_next[7:0];
    v_sq         = v * v;
    color_calc   = {v, 16'b0} | {v_sq, 8'b0} | {16'b0, CHAN_MAX - v};
  end

  logic emit_ok;
  assign emit_ok = !out_valid || result.ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (pixel.valid) state_next = S_MAP_RE;
      S_MAP_RE: state_next = S_MAP_IM;
      S_MAP_IM: state_next = S_INIT;
      S_INIT:   state_next = S_SQ_R;
      S_SQ_R:   state_next = S_SQ_I;
      S_SQ_I:   state_next = S_CHECK;
      S_CHECK: begin
        if (escaped) begin
          state_next = S_DIV;
        end else if (at_limit) begin
          state_next = S_EMIT;
        end else begin
          state_next = S_STEP;
        end
      end
      S_STEP:   state_next = S_SQ_R;
      S_DIV:    if (div_cnt == '0) state_next = S_EMIT;
      S_EMIT:   if (emit_ok) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign pixel.ready = (state == S_IDLE);

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        col <= pixel.pixel_col;
        row <= pixel.pixel_row;
      end
      S_MAP_IM: point_re <= map_val;
      S_INIT: begin
        // Mandelbrot: z = 0, c = point. Julia: z = point, c = constant.
        zr      <= set_select ? '0 : point_re;
        zi      <= set_select ? '0 : map_val;
        cre     <= set_select ? point_re : julia_re;
        cim     <= set_select ? map_val : julia_im;
        n       <= '0;
        stepped <= 1'b0;
      end
      S_SQ_I: sqr <= sq_now;
      S_CHECK: begin
        sqi     <= sq_now;
        div_rem <= '0;
        div_cnt <= DIV_CNT_W'(DIV_W - 1);
        if (!escaped) begin
          n <= n_cur;
        end
        div_num   <= {n, 8'b0} - {8'b0, n};
        res_count <= escaped ? n : n_cur;
        res_color <= '0;
      end
      S_STEP: begin
        zr      <= zr_next;
        zi      <= zi_next;
        stepped <= 1'b1;
      end
      S_DIV: begin
        div_rem <= div_rem_next;
        div_num <= div_num_next;
        div_cnt <= div_cnt - DIV_CNT_W'(1);
        if (div_cnt == '0) begin
          res_color <= color_calc;
        end
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_EMIT && emit_ok) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_EMIT && emit_ok) begin
      result.out_col      <= col;
      result.out_row      <= row;
      result.escape_count <= res_count;
      result.pixel_color  <= res_color;
    end
  end

  assign result.valid = out_valid;

  // Checks
  a_count_in_range: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> result.escape_count <= iter_limit)
    else $error("escape count above iteration limit");

  a_black_at_limit: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.escape_count == iter_limit) |-> result.pixel_color == '0)
    else $error("pixel at limit not black");

  a_step_below_limit: assert property (@(posedge clk) disable iff (rst)
    (state == S_STEP) |-> n < iter_limit)
    else $error("iteration step past the limit");

  a_div_remainder: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> div_rem < iter_limit)
    else $error("divider remainder out of range");

endmodule
